// ===== rtl/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg
// shared widths, defaults and codes for the rgb to hsv converter
// ----------------------------------------------------------------------------
package rhc_pkg;

	// channel and result field widths
	localparam int CH_W  = 8;
	localparam int HUE_W = 16;
	localparam int SAT_W = 17;
	localparam int VAL_W = 8;

	// default number of fraction bits of hue and saturation
	localparam int FRAC_BITS_DEF = 16;

	// hue numerator and divisor widths (6 * 255 fits in 11 bits)
	localparam int NUM_W = 11;

	// channel that holds the maximum, ties go red, then green, then blue
	typedef enum logic [2:0] {
		WIN_RED   = 3'b001,
		WIN_GREEN = 3'b010,
		WIN_BLUE  = 3'b100
	} win_t;

endpackage

// ===== rtl/rgb_to_hsv_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// 8-bit rgb pixel in, fixed-point hue, saturation and value out.
//
// input: a pixel beat (red, green, blue) is taken at a rising edge with start
// high and busy low. busy is always low: a new pixel may enter every cycle.
// output: done is high for exactly one cycle with hue, saturation and
// brightness_value valid; the receiver has no way to hold results off and
// none is needed, since nothing in the pipe ever waits.
// pipeline: one stage finds max, min and the winning channel, one forms the hue
// numerator and loads both dividers, FRAC_BITS stages each resolve one quotient
// bit of both dividers (saturation and hue side by side), and one output
// register follows. throughput is one pixel per clock, set by the
// one-bit-per-stage restoring divider chain.
// reset: arst_n clears all valid bits at once; pixels in flight are dropped
// and no done strobe follows for them.
// black and grey pixels give hue and saturation zero.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter #(
	parameter int FRAC_BITS = rhc_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [rhc_pkg::CH_W-1:0]  red,
	input  logic [rhc_pkg::CH_W-1:0]  green,
	input  logic [rhc_pkg::CH_W-1:0]  blue,
	output logic                      done,
	output logic [rhc_pkg::HUE_W-1:0] hue,
	output logic [rhc_pkg::SAT_W-1:0] saturation,
	output logic [rhc_pkg::VAL_W-1:0] brightness_value
);

	localparam int CW   = rhc_pkg::CH_W;
	localparam int NW   = rhc_pkg::NUM_W;
	localparam int HW   = (FRAC_BITS > rhc_pkg::HUE_W) ? FRAC_BITS : rhc_pkg::HUE_W;
	localparam int SW   = (FRAC_BITS + 1 > rhc_pkg::SAT_W) ? FRAC_BITS + 1 : rhc_pkg::SAT_W;
	localparam int LAT  = FRAC_BITS + 2;

	logic accept;

	// the pipe never stalls
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// ------------------------------------------------------------------
	// stage 1: max, min, delta, winning channel, channel difference
	// ------------------------------------------------------------------
	logic [CW-1:0]     mx_c, mn_c;
	rhc_pkg::win_t     win_c;
	logic signed [CW:0] diff_c;

	logic              vld_s1;
	logic [CW-1:0]     mx_s1, mn_s1, delta_s1;
	rhc_pkg::win_t     win_s1;
	logic signed [CW:0] diff_s1;

	// max with red, green, blue priority on ties, and the matching difference
	always_comb begin
		mx_c   = red;
		win_c  = rhc_pkg::WIN_RED;
		diff_c = $signed({1'b0, green}) - $signed({1'b0, blue});
		if (green > mx_c && green >= blue) begin
			mx_c   = green;
			win_c  = rhc_pkg::WIN_GREEN;
			diff_c = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else if (blue > red && blue > green) begin
			mx_c   = blue;
			win_c  = rhc_pkg::WIN_BLUE;
			diff_c = $signed({1'b0, red}) - $signed({1'b0, green});
		end
		mn_c = red;
		if (green < mn_c) mn_c = green;
		if (blue < mn_c) mn_c = blue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		mx_s1    <= mx_c;
		mn_s1    <= mn_c;
		delta_s1 <= mx_c - mn_c;
		win_s1   <= win_c;
		diff_s1  <= diff_c;
	end

	// ------------------------------------------------------------------
	// stage 2 chain: entry 0 loads the divider operands, entries 1..F
	// each resolve one quotient bit of both dividers
	// ------------------------------------------------------------------
	logic                 vld_s2      [FRAC_BITS+1];
	logic [CW-1:0]        mx_s2       [FRAC_BITS+1];
	logic [NW-1:0]        six_s2      [FRAC_BITS+1];
	logic [CW-1:0]        sat_rem_s2  [FRAC_BITS+1];
	logic [NW-1:0]        hue_rem_s2  [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] sat_q_s2    [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] hue_q_s2    [FRAC_BITS+1];
	logic                 full_s2     [FRAC_BITS+1];
	logic                 zero_s2     [FRAC_BITS+1];

	logic [NW-1:0]         six_c;
	logic [NW-2:0]         sector_c;
	logic signed [NW:0]    num_raw_c;
	logic signed [NW:0]    num_wrap_c;
	logic                  full_c, zero_c;

	// hue numerator with sector offset, wrapped by a full turn when negative
	always_comb begin
		six_c = NW'({delta_s1, 2'b00}) + NW'({delta_s1, 1'b0});
		case (win_s1)
			rhc_pkg::WIN_RED:   sector_c = '0;
			rhc_pkg::WIN_GREEN: sector_c = (NW-1)'({delta_s1, 1'b0});
			rhc_pkg::WIN_BLUE:  sector_c = (NW-1)'({delta_s1, 2'b00});
			default:            sector_c = '0;
		endcase
		num_raw_c  = $signed({2'b00, sector_c}) + (NW+1)'(diff_s1);
		num_wrap_c = num_raw_c;
		if (num_raw_c < 0) begin
			num_wrap_c = num_raw_c + $signed({1'b0, six_c});
		end
		zero_c = (delta_s1 == '0);
		full_c = (mn_s1 == '0) && !zero_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2[0] <= 1'b0;
		end else begin
			vld_s2[0] <= vld_s1;
		end
	end

	// delta equal to max means saturation is exactly one: skip that division
	always_ff @(posedge clk) begin
		mx_s2[0]      <= mx_s1;
		six_s2[0]     <= six_c;
		sat_rem_s2[0] <= (full_c || zero_c) ? '0 : delta_s1;
		hue_rem_s2[0] <= zero_c ? '0 : num_wrap_c[NW-1:0];
		sat_q_s2[0]   <= '0;
		hue_q_s2[0]   <= '0;
		full_s2[0]    <= full_c;
		zero_s2[0]    <= zero_c;
	end

	genvar j;
	generate
		for (j = 1; j <= FRAC_BITS; j++) begin : g_div
			logic [CW:0] sat_sh;
			logic [NW:0] hue_sh;
			logic        sat_ge, hue_ge;
			logic [CW:0] sat_sub;
			logic [NW:0] hue_sub;
			logic [FRAC_BITS-1:0] sat_qn, hue_qn;

			// restoring step: shift, compare, subtract, set one quotient bit
			always_comb begin
				sat_sh  = {sat_rem_s2[j-1], 1'b0};
				hue_sh  = {hue_rem_s2[j-1], 1'b0};
				sat_ge  = sat_sh >= {1'b0, mx_s2[j-1]};
				hue_ge  = hue_sh >= {1'b0, six_s2[j-1]};
				sat_sub = sat_ge ? sat_sh - {1'b0, mx_s2[j-1]} : sat_sh;
				hue_sub = hue_ge ? hue_sh - {1'b0, six_s2[j-1]} : hue_sh;
				sat_qn  = sat_q_s2[j-1];
				hue_qn  = hue_q_s2[j-1];
				sat_qn[FRAC_BITS-j] = sat_ge;
				hue_qn[FRAC_BITS-j] = hue_ge;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s2[j] <= 1'b0;
				end else begin
					vld_s2[j] <= vld_s2[j-1];
				end
			end

			always_ff @(posedge clk) begin
				mx_s2[j]      <= mx_s2[j-1];
				six_s2[j]     <= six_s2[j-1];
				sat_rem_s2[j] <= sat_sub[CW-1:0];
				hue_rem_s2[j] <= hue_sub[NW-1:0];
				sat_q_s2[j]   <= sat_qn;
				hue_q_s2[j]   <= hue_qn;
				full_s2[j]    <= full_s2[j-1];
				zero_s2[j]    <= zero_s2[j-1];
			end
		end
	endgenerate

	// ------------------------------------------------------------------
	// stage 3: special cases and field widths, output register
	// ------------------------------------------------------------------
	logic [HW-1:0] hue_ext_c;
	logic [SW-1:0] sat_ext_c;

	logic                      vld_s3;
	logic [rhc_pkg::HUE_W-1:0] hue_s3;
	logic [rhc_pkg::SAT_W-1:0] sat_s3;
	logic [rhc_pkg::VAL_W-1:0] val_s3;

	always_comb begin
		hue_ext_c = HW'(hue_q_s2[FRAC_BITS]);
		sat_ext_c = SW'({full_s2[FRAC_BITS], sat_q_s2[FRAC_BITS]});
		if (zero_s2[FRAC_BITS]) begin
			hue_ext_c = '0;
			sat_ext_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2[FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		hue_s3 <= hue_ext_c[rhc_pkg::HUE_W-1:0];
		sat_s3 <= sat_ext_c[rhc_pkg::SAT_W-1:0];
		val_s3 <= rhc_pkg::VAL_W'(mx_s2[FRAC_BITS]);
	end

	assign done             = vld_s3;
	assign hue              = hue_s3;
	assign saturation       = sat_s3;
	assign brightness_value = val_s3;

`ifndef ASSERT_OFF
	// every accepted beat enters the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> vld_s1)
		else $error("accepted pixel did not enter stage 1");

	// every accepted beat comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##LAT done)
		else $error("result missing after pipeline latency");

	// a strobe only follows a valid last divider step
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s2[FRAC_BITS]))
		else $error("done without a valid divider result");

	// black pixels carry no hue and no saturation
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && brightness_value == '0) |-> (hue == '0 && saturation == '0))
		else $error("black pixel with nonzero hue or saturation");
`endif

endmodule

// ===== test/rgb_to_hsv_converter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_tb
// Self-checking bench for the rgb to hsv converter. Pixels go in through the
// start/busy handshake with random idle bursts on the sender side. Each
// accepted pixel is turned into an expected hue, saturation and value by an
// exact integer model kept in a scoreboard. Every done beat is checked in
// order against the oldest expected result.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_tb;

	localparam int STALL_LIMIT = 1000;
	localparam int N_RANDOM    = 1530;
	localparam int N_TAIL      = 150;
	localparam int DRAIN_WAIT  = rhc_pkg::FRAC_BITS_DEF + 8;

	// one expected result, with the pixel it came from for reporting
	typedef struct packed {
		logic [rhc_pkg::HUE_W-1:0] hue;
		logic [rhc_pkg::SAT_W-1:0] sat;
		logic [rhc_pkg::VAL_W-1:0] val;
	} hsv_t;

	typedef struct {
		logic [rhc_pkg::CH_W-1:0] red;
		logic [rhc_pkg::CH_W-1:0] green;
		logic [rhc_pkg::CH_W-1:0] blue;
		hsv_t                     hsv;
	} pixel_hsv_t;

	// scoreboard: converts pixels to expected hsv and checks done beats
	class hsv_scoreboard;
		pixel_hsv_t pending_hsv[$];
		int         pixels_in;
		int         results_in;
		int         mismatches;

		function new();
			pixels_in  = 0;
			results_in = 0;
			mismatches = 0;
		endfunction

		// exact integer hsv, ties go red, then green, then blue
		function hsv_t calc_hsv(logic [rhc_pkg::CH_W-1:0] r,
				logic [rhc_pkg::CH_W-1:0] g, logic [rhc_pkg::CH_W-1:0] b);
			rhc_pkg::win_t     win;
			longint            rr, gg, bb, mx, mn, dl, num;
			longint unsigned   one, sat_full, hue_full;
			hsv_t              res;
			rr  = r;
			gg  = g;
			bb  = b;
			mx  = rr;
			win = rhc_pkg::WIN_RED;
			if (gg > mx) begin
				mx  = gg;
				win = rhc_pkg::WIN_GREEN;
			end
			if (bb > mx) begin
				mx  = bb;
				win = rhc_pkg::WIN_BLUE;
			end
			mn = rr;
			if (gg < mn) mn = gg;
			if (bb < mn) mn = bb;
			dl  = mx - mn;
			res = '0;
			res.val = mx[rhc_pkg::VAL_W-1:0];
			// black and grey pixels keep hue and saturation at zero
			if (mx != 0 && dl != 0) begin
				one      = 64'd1 << rhc_pkg::FRAC_BITS_DEF;
				sat_full = (unsigned'(dl) * one) / unsigned'(mx);
				case (win)
					rhc_pkg::WIN_RED:   num = gg - bb;
					rhc_pkg::WIN_GREEN: num = 2 * dl + (bb - rr);
					default:            num = 4 * dl + (rr - gg);
				endcase
				// negative hue wraps by a full turn
				if (num < 0) num += 6 * dl;
				hue_full = (unsigned'(num) * one) / unsigned'(6 * dl);
				res.sat  = sat_full[rhc_pkg::SAT_W-1:0];
				res.hue  = hue_full[rhc_pkg::HUE_W-1:0];
			end
			return res;
		endfunction

		function void note_pixel(logic [rhc_pkg::CH_W-1:0] r,
				logic [rhc_pkg::CH_W-1:0] g, logic [rhc_pkg::CH_W-1:0] b);
			pixel_hsv_t ent;
			ent.red   = r;
			ent.green = g;
			ent.blue  = b;
			ent.hsv   = calc_hsv(r, g, b);
			pending_hsv.push_back(ent);
			pixels_in++;
		endfunction

		function void check_result(hsv_t got);
			pixel_hsv_t ent;
			results_in++;
			if (pending_hsv.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result hue=%0d sat=%0d val=%0d",
						$realtime, got.hue, got.sat, got.val);
				return;
			end
			ent = pending_hsv.pop_front();
			if (got.hue !== ent.hsv.hue || got.sat !== ent.hsv.sat ||
					got.val !== ent.hsv.val) begin
				mismatches++;
				if (mismatches <= 10) begin
					$write("%0t: rgb=(%0d,%0d,%0d) expected hue=%0d sat=%0d val=%0d",
						$realtime, ent.red, ent.green, ent.blue,
						ent.hsv.hue, ent.hsv.sat, ent.hsv.val);
					$display(" got hue=%0d sat=%0d val=%0d",
						got.hue, got.sat, got.val);
				end
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       start  = 1'b0;
	logic [rhc_pkg::CH_W-1:0]   red    = '0;
	logic [rhc_pkg::CH_W-1:0]   green  = '0;
	logic [rhc_pkg::CH_W-1:0]   blue   = '0;
	logic                       busy;
	logic                       done;
	logic [rhc_pkg::HUE_W-1:0]  hue;
	logic [rhc_pkg::SAT_W-1:0]  saturation;
	logic [rhc_pkg::VAL_W-1:0]  brightness_value;

	hsv_scoreboard sb = new();
	int            n_directed;

	rgb_to_hsv_converter u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.red              (red),
		.green            (green),
		.blue             (blue),
		.done             (done),
		.hue              (hue),
		.saturation       (saturation),
		.brightness_value (brightness_value)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// note accepted pixels and check done beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) sb.note_pixel(red, green, blue);
			if (done) sb.check_result('{hue, saturation, brightness_value});
		end
	end

	// watchdog on cycles with no beat on either side
	initial begin : watchdog
		int stall;
		stall = 0;
		@(posedge arst_n);
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done) stall = 0;
			else stall++;
		end
		$display("rgb_to_hsv_converter test failed");
		$finish;
	end

	// hold one pixel on the inputs until it is taken
	task automatic send_pixel(logic [rhc_pkg::CH_W-1:0] r,
			logic [rhc_pkg::CH_W-1:0] g, logic [rhc_pkg::CH_W-1:0] b);
		start <= 1'b1;
		red   <= r;
		green <= g;
		blue  <= b;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// sender idle burst, with noise on the channel inputs
	task automatic idle_cycles(int n);
		start <= 1'b0;
		repeat (n) begin
			red   <= rhc_pkg::CH_W'($urandom_range(0, 255));
			green <= rhc_pkg::CH_W'($urandom_range(0, 255));
			blue  <= rhc_pkg::CH_W'($urandom_range(0, 255));
			@(posedge clk);
		end
	endtask

	// random pixel, weighted toward ties, greys, small values and the channel extremes
	task automatic pick_pixel(output logic [rhc_pkg::CH_W-1:0] r,
			output logic [rhc_pkg::CH_W-1:0] g, output logic [rhc_pkg::CH_W-1:0] b);
		logic [rhc_pkg::CH_W-1:0] top, other;
		int                       kind;
		kind  = $urandom_range(0, 9);
		r     = rhc_pkg::CH_W'($urandom_range(0, 255));
		g     = rhc_pkg::CH_W'($urandom_range(0, 255));
		b     = rhc_pkg::CH_W'($urandom_range(0, 255));
		top   = rhc_pkg::CH_W'($urandom_range(1, 255));
		other = rhc_pkg::CH_W'($urandom_range(0, top));
		case (kind)
			5: begin
				// grey
				g = r;
				b = r;
			end
			6: begin
				// two channels tied for the maximum
				case ($urandom_range(0, 2))
					0:       begin r = top; g = top; b = other; end
					1:       begin r = other; g = top; b = top; end
					default: begin r = top; g = other; b = top; end
				endcase
			end
			7: begin
				// small values, tiny delta
				r = rhc_pkg::CH_W'($urandom_range(0, 3));
				g = rhc_pkg::CH_W'($urandom_range(0, 3));
				b = rhc_pkg::CH_W'($urandom_range(0, 3));
			end
			8: begin
				// channels at the rails
				r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			end
			default: ;
		endcase
	endtask

	// stimulus and end of run
	initial begin : main
		logic [rhc_pkg::CH_W-1:0] r, g, b;
		bit                       bursty;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pixels: black, grey, white, primaries, ties, hue wrap
		send_pixel(8'd0,   8'd0,   8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd1,   8'd1,   8'd1);
		send_pixel(8'd255, 8'd0,   8'd0);
		send_pixel(8'd0,   8'd255, 8'd0);
		send_pixel(8'd0,   8'd0,   8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0,   8'd255, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd255);
		idle_cycles(3);
		send_pixel(8'd255, 8'd0,   8'd1);
		send_pixel(8'd1,   8'd0,   8'd0);
		send_pixel(8'd0,   8'd1,   8'd0);
		send_pixel(8'd0,   8'd0,   8'd1);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd254, 8'd255, 8'd0);
		send_pixel(8'd1,   8'd1,   8'd0);
		send_pixel(8'd255, 8'd128, 8'd0);
		send_pixel(8'd10,  8'd200, 8'd100);
		send_pixel(8'd200, 8'd10,  8'd200);
		send_pixel(8'd85,  8'd170, 8'd170);
		send_pixel(8'd170, 8'd85,  8'd255);
		n_directed = 22;

		// random pixels, in stretches of 64 that are quiet or bursty at random
		bursty = 1'b0;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 64 == 0) bursty = ($urandom_range(0, 1) == 1);
			pick_pixel(r, g, b);
			send_pixel(r, g, b);
			if (i < N_RANDOM - N_TAIL && bursty && $urandom_range(0, 2) == 0)
				idle_cycles($urandom_range(1, 10));
		end
		start <= 1'b0;

		// drain the pipe, then watch for stray done beats
		while (sb.pending_hsv.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d pixels sent (%0d directed), %0d results checked, %0d mismatches",
			sb.pixels_in, n_directed, sb.results_in, sb.mismatches);
		$display("covered black, grey, primary, tied-maximum and hue-wrap pixels");
		if (sb.mismatches == 0 && sb.pending_hsv.size() == 0)
			$display("rgb_to_hsv_converter test passed");
		else
			$display("rgb_to_hsv_converter test failed");
		$finish;
	end

endmodule
